// File: sv/mono_page_framebuffer_draw_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page-packed frame buffer
// Shared clocked assertion forms, sampled on clk_i with reset masked.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH

// prop must hold at every clock edge outside reset
`define MPFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define MPFB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, operation codes and controller/datapath types.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  localparam logic [2:0] KIND_WR_PIX = 3'd0;
  localparam logic [2:0] KIND_RD_PIX = 3'd1;
  localparam logic [2:0] KIND_FILL   = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_RD_BYTE = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic rmw;
    logic fill_rd;
    logic fill_wr;
    logic sweep;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] in_kind;
    logic       in_fill_go;
    logic       sweep_last;
    logic       fill_last;
  } stat_t;

endpackage

// File: sv/mpfb_dp.sv
// ----------------------------------------------------------------------------
// mpfb_dp
// Frame store, item registers, fill cursor, clear sweep and result register.
// ----------------------------------------------------------------------------
module mpfb_dp #(
  parameter int DISPLAY_WIDTH  = mpfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfb_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpfb_pkg::cmd_t    cmd_i,
  output mpfb_pkg::stat_t   stat_o,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        pos_x_i,
  input  logic [6:0]        pos_y_i,
  input  logic [7:0]        rect_width_i,
  input  logic [6:0]        rect_height_i,
  input  logic              colour_i,
  input  logic [9:0]        byte_index_i,
  output logic              pixel_value_o,
  output logic [7:0]        byte_value_o,
  output logic              rejected_o
);

  localparam int PageCount  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int StoreBytes = PageCount * DISPLAY_WIDTH;
  localparam int AW         = $clog2(StoreBytes);
  localparam int IW         = (AW >= 10) ? AW + 1 : 11;
  localparam int MW         = AW + 8;

  logic [7:0]    mem_q [StoreBytes];
  logic [7:0]    rdata_q;

  logic [2:0]    kind_q;
  logic [7:0]    x_q;
  logic [6:0]    y_q;
  logic [7:0]    w_q;
  logic [6:0]    h_q;
  logic          colour_q;
  logic [9:0]    idx_q;
  logic [7:0]    col_q, col_d;
  logic [3:0]    page_q, page_d;
  logic [AW-1:0] sweep_q, sweep_d;

  logic          pix_q, rej_q;
  logic [7:0]    byte_q;

  logic          re, we;
  logic [AW-1:0] raddr, waddr, cur_addr;
  logic [7:0]    wdata, fill_mask, pix_mask;
  logic [7:0]    x_last;
  logic [3:0]    page_last;
  logic [8:0]    x_last_sum;
  logic [7:0]    y_last_sum;
  logic          on_disp_l, idx_ok_l;
  logic          res_pix, res_rej;
  logic [7:0]    res_byte;

  function automatic logic on_disp(input logic [7:0] x, input logic [6:0] y);
    return (9'(x) < 9'(DISPLAY_WIDTH)) && (8'(y) < 8'(DISPLAY_HEIGHT));
  endfunction

  function automatic logic fill_rej(input logic [7:0] x, input logic [6:0] y,
                                    input logic [7:0] w, input logic [6:0] h);
    return !on_disp(x, y) || (9'(x) + 9'(w) > 9'(DISPLAY_WIDTH)) ||
           (8'(y) + 8'(h) > 8'(DISPLAY_HEIGHT));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [3:0] pg, input logic [7:0] col);
    logic [MW-1:0] full;
    full = MW'(pg) * MW'(DISPLAY_WIDTH) + MW'(col);
    return full[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_addr(input logic [9:0] idx);
    logic [IW-1:0] ext;
    ext = IW'(idx);
    return ext[AW-1:0];
  endfunction

  // decode of the offered item, used by the controller at accept
  assign stat_o.in_kind    = kind_i;
  assign stat_o.in_fill_go = !fill_rej(pos_x_i, pos_y_i, rect_width_i, rect_height_i) &&
                             (rect_width_i != 8'd0) && (rect_height_i != 7'd0);

  assign x_last_sum = 9'(x_q) + 9'(w_q) - 9'd1;
  assign y_last_sum = 8'(y_q) + 8'(h_q) - 8'd1;
  assign x_last     = x_last_sum[7:0];
  assign page_last  = y_last_sum[6:3];

  assign stat_o.fill_last  = (col_q == x_last) && (page_q == page_last);
  assign stat_o.sweep_last = (sweep_q == AW'(StoreBytes - 1));

  assign cur_addr = addr_of(page_q, col_q);

  always_comb begin
    logic [6:0] row;
    fill_mask = '0;
    for (int b = 0; b < 8; b++) begin
      row = {page_q, 3'(b)};
      fill_mask[b] = (8'(row) >= 8'(y_q)) && (8'(row) < 8'(y_q) + 8'(h_q));
    end
  end

  assign pix_mask = 8'd1 << y_q[2:0];

  assign on_disp_l = on_disp(x_q, y_q);
  assign idx_ok_l  = (IW'(idx_q) < IW'(StoreBytes));

  // memory port selection
  always_comb begin
    re    = cmd_i.load | cmd_i.fill_rd;
    raddr = cur_addr;
    if (cmd_i.load) begin
      raddr = (kind_i == mpfb_pkg::KIND_RD_BYTE) ? idx_addr(byte_index_i) :
                                                   addr_of(pos_y_i[6:3], pos_x_i);
    end
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    if (cmd_i.sweep) begin
      we    = 1'b1;
      waddr = sweep_q;
    end else if (cmd_i.fill_wr) begin
      we    = 1'b1;
      wdata = colour_q ? (rdata_q | fill_mask) : (rdata_q & ~fill_mask);
    end else if (cmd_i.rmw && (kind_q == mpfb_pkg::KIND_WR_PIX) && on_disp_l) begin
      we    = 1'b1;
      wdata = colour_q ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result of the current item
  always_comb begin
    res_pix  = 1'b0;
    res_byte = '0;
    res_rej  = 1'b0;
    unique case (kind_q)
      mpfb_pkg::KIND_WR_PIX: begin
        res_rej = !on_disp_l;
      end
      mpfb_pkg::KIND_RD_PIX: begin
        res_rej = !on_disp_l;
        res_pix = on_disp_l & rdata_q[y_q[2:0]];
      end
      mpfb_pkg::KIND_FILL: begin
        res_rej = fill_rej(x_q, y_q, w_q, h_q);
      end
      mpfb_pkg::KIND_RD_BYTE: begin
        res_rej  = !idx_ok_l;
        res_byte = idx_ok_l ? rdata_q : 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    col_d  = col_q;
    page_d = page_q;
    if (cmd_i.load) begin
      col_d  = pos_x_i;
      page_d = pos_y_i[6:3];
    end else if (cmd_i.fill_wr) begin
      if (col_q == x_last) begin
        col_d  = x_q;
        page_d = page_q + 4'd1;
      end else begin
        col_d = col_q + 8'd1;
      end
    end
  end

  assign sweep_d = stat_o.sweep_last ? '0 : sweep_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    page_q <= page_d;
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      w_q      <= rect_width_i;
      h_q      <= rect_height_i;
      colour_q <= colour_i;
      idx_q    <= byte_index_i;
    end
    if (cmd_i.out_load) begin
      pix_q  <= res_pix;
      byte_q <= res_byte;
      rej_q  <= res_rej;
    end
  end

  assign pixel_value_o = pix_q;
  assign byte_value_o  = byte_q;
  assign rejected_o    = rej_q;

endmodule

// File: sv/mpfb_ctrl.sv
// ----------------------------------------------------------------------------
// mpfb_ctrl
// Sequencer for accept, read-modify-write, fill walk, clear sweep and result.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_defines.svh"

module mpfb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mpfb_pkg::stat_t  stat_i,
  output mpfb_pkg::cmd_t   cmd_o
);

  mpfb_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpfb_pkg::ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mpfb_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = mpfb_pkg::ST_IDLE;
        end
      end
      mpfb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (stat_i.in_kind)
            mpfb_pkg::KIND_WR_PIX,
            mpfb_pkg::KIND_RD_PIX,
            mpfb_pkg::KIND_RD_BYTE: state_d = mpfb_pkg::ST_RMW;
            mpfb_pkg::KIND_FILL:    state_d = stat_i.in_fill_go ? mpfb_pkg::ST_FILL_RD :
                                                                  mpfb_pkg::ST_DONE;
            mpfb_pkg::KIND_CLEAR:   state_d = mpfb_pkg::ST_CLEAR;
            default:                state_d = mpfb_pkg::ST_DONE;
          endcase
        end
      end
      mpfb_pkg::ST_RMW: begin
        cmd_o.rmw = 1'b1;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpfb_pkg::ST_IDLE;
        end else begin
          state_d = mpfb_pkg::ST_DONE;
        end
      end
      mpfb_pkg::ST_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = mpfb_pkg::ST_FILL_WR;
      end
      mpfb_pkg::ST_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = stat_i.fill_last ? mpfb_pkg::ST_DONE : mpfb_pkg::ST_FILL_RD;
      end
      mpfb_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = mpfb_pkg::ST_DONE;
        end
      end
      mpfb_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `MPFB_ASSERT(a_load_into_free, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwrote pending transaction")
  `MPFB_ASSERT_NEVER(a_no_accept_in_sweep, cmd_o.sweep && in_ready_o, "accept during clear sweep")
  `MPFB_ASSERT(a_wr_after_rd, cmd_o.fill_wr |-> $past(cmd_o.fill_rd), "fill write without read")
  `MPFB_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o, "back to back accept")

endmodule

// File: sv/mono_page_framebuffer_draw.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// Monochrome page-packed frame store with pixel, fill, clear and byte access.
// ----------------------------------------------------------------------------
// One item is worked at a time, and its result sits in an output register so
// the next item is taken while that result waits. The store is a single
// memory with a registered read port, so a pixel write, pixel read or byte
// read is an accept with read, then a modify/write and result. A rejected or
// empty fill and an unknown kind go from accept straight to the result. A
// fill walks each rectangle byte column by column over the pages touched:
// each byte is a read then a masked write. Clear all writes the whole store,
// one byte a cycle. After reset a clearing pass over PAGES * DISPLAY_WIDTH
// bytes (1024 at the default size) runs with in_ready_o low.
module mono_page_framebuffer_draw #(
  parameter int DISPLAY_WIDTH  = mpfb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfb_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] pos_x_i,
  input  logic [6:0] pos_y_i,
  input  logic [7:0] rect_width_i,
  input  logic [6:0] rect_height_i,
  input  logic       colour_i,
  input  logic [9:0] byte_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       pixel_value_o,
  output logic [7:0] byte_value_o,
  output logic       rejected_o
);

  mpfb_pkg::cmd_t  cmd;
  mpfb_pkg::stat_t stat;

  mpfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mpfb_dp #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .colour_i      (colour_i),
    .byte_index_i  (byte_index_i),
    .pixel_value_o (pixel_value_o),
    .byte_value_o  (byte_value_o),
    .rejected_o    (rejected_o)
  );

endmodule
